FILE: design/buddy_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared property shorthands for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Request and response types and operation and status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OOM    = 3'd1;
  localparam logic [2:0] ST_BIG    = 3'd2;
  localparam logic [2:0] ST_BADIDX = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] page_count;
    logic [10:0] page_index;
    logic [3:0]  block_tag;
  } bpa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  result_page;
    logic [10:0] block_pages;
    logic [3:0]  result_tag;
    logic [10:0] free_page_total;
  } bpa_rsp_t;

endpackage

FILE: design/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Single-pool power-of-two page allocator over a per-page state memory.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as bpa_req_t: allocate, free or query.
// Each request returns one bpa_rsp_t on out_valid/out_ready, in order.
// One request is in work at a time; a sequencer reads, modifies and writes a
// per-page memory through a registered read port. Steps from accept to out_valid:
//   rejected on entry (zero, too large, bad index, no room): no memory access
//   query, or free of a page that is no block start: one read of the page entry
//   allocate: a scan over the orders, a walk over each list entry passed over,
//     an unlink of the taken block with two neighbour link writes when it is
//     mid-list, a split per level and a step per order the largest free order drops
//   out of memory after a scan: the scan over empty orders and the entries checked
//   free: a merge step per level while the buddy is free, then a push onto the
//     target list, with a link write when that list already holds a block
// The allocator is idle for the next request as its predecessor's response turns valid.
// After reset, and after every write on cfg_valid/cfg_ready, the page memory
// is swept over all 2**$clog2(MAX_PAGES) entries (1024 by default) while
// in_ready stays low; cfg_ready is always high.
// A stalled response holds in the output register; the next request is
// accepted meanwhile and waits before its own response while out_ready is low.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int MAX_PAGES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpa_pkg::bpa_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bpa_pkg::bpa_rsp_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [10:0]      cfg_usable_pages
);

  import bpa_pkg::*;

  localparam int PW = $clog2(MAX_PAGES);
  localparam int OW = $clog2(PW + 1);
  localparam int NO = PW + 1;
  localparam int UW = (PW + 1 > 11) ? PW + 1 : 11;
  localparam int SW = UW + 1;
  localparam logic [UW-1:0] MAX_U = UW'(MAX_PAGES);

  typedef struct packed {
    logic [PW-1:0] link_next;
    logic [PW-1:0] link_prev;
    logic [OW-1:0] page_order;
    logic          on_list;
    logic [3:0]    page_tag;
    logic          is_head;
  } page_ent_t;

  localparam int EW = $bits(page_ent_t);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SCAN  = 5'd1;
  localparam logic [4:0] S_CHECK = 5'd2;
  localparam logic [4:0] S_WALK  = 5'd3;
  localparam logic [4:0] S_AGET  = 5'd4;
  localparam logic [4:0] S_UL    = 5'd5;
  localparam logic [4:0] S_UL2   = 5'd6;
  localparam logic [4:0] S_UL3   = 5'd7;
  localparam logic [4:0] S_SPLIT = 5'd8;
  localparam logic [4:0] S_LINK  = 5'd9;
  localparam logic [4:0] S_AFIN  = 5'd10;
  localparam logic [4:0] S_MFO   = 5'd11;
  localparam logic [4:0] S_HREAD = 5'd12;
  localparam logic [4:0] S_MERGE = 5'd13;
  localparam logic [4:0] S_MCHK  = 5'd14;
  localparam logic [4:0] S_MSTEP = 5'd15;
  localparam logic [4:0] S_PUSH  = 5'd16;
  localparam logic [4:0] S_RESP  = 5'd17;

  function automatic logic [OW-1:0] order_of(input logic [UW-1:0] v);
    logic [UW-1:0] m;
    logic [OW-1:0] o;
    m = v - 1'b1;
    o = '0;
    for (int i = 0; i < UW; i++) begin
      if (m[i]) o = OW'(i + 1);
    end
    if (v == '0) o = '0;
    return o;
  endfunction

  function automatic logic [10:0] pages_of(input logic [OW-1:0] o);
    logic [SW-1:0] t;
    t = SW'(1) << o;
    return t[10:0];
  endfunction

  function automatic logic [UW-1:0] usable_in(input logic [PW-1:0] s,
                                              input logic [OW-1:0] o,
                                              input logic [UW-1:0] u);
    logic [SW-1:0] e;
    e = SW'(s) + (SW'(1) << o);
    if (e > SW'(u)) e = SW'(u);
    return UW'(e - SW'(s));
  endfunction

  localparam logic [OW-1:0] TOP0 = OW'(PW);

  // control
  logic [4:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          clr_r;
  logic [PW-1:0] clr_addr_r;
  logic [UW-1:0] usable_r, free_r, free_nxt;
  logic [OW-1:0] top_r, mfo_r, mfo_nxt;
  logic [PW-1:0] first_r [NO];
  logic [PW-1:0] last_r [NO];
  logic          full_r [NO];

  // payload
  logic [1:0]    func_r, func_nxt;
  logic [10:0]   cnt_r, cnt_nxt;
  logic [10:0]   pidx_r, pidx_nxt;
  logic [3:0]    tag_r, tag_nxt;
  logic [OW-1:0] ord_r, ord_nxt, a_r, a_nxt, uo_r, uo_nxt, co_r, co_nxt;
  logic [PW-1:0] cur_r, cur_nxt, blk_r, blk_nxt, tgt_r, tgt_nxt;
  logic [PW-1:0] lk_addr_r, lk_addr_nxt, lk_val_r, lk_val_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic [PW-1:0] res_page_r, res_page_nxt;
  logic [10:0]   res_pages_r, res_pages_nxt;
  logic [3:0]    res_tag_r, res_tag_nxt;
  bpa_rsp_t      out_r, out_nxt;

  // list register port
  logic [OW-1:0] lidx;
  logic [PW-1:0] lf, ll;
  logic          lfull;
  logic          l_we_first, l_we_last, l_we_full, l_full_val;
  logic [PW-1:0] l_first_val, l_last_val;

  // memory port
  logic          fsm_we, mem_we, mem_re;
  logic [PW-1:0] fsm_waddr, mem_waddr, mem_raddr;
  page_ent_t     fsm_wbe, fsm_wdata, mem_wbe, mem_wdata, rd;
  logic [EW-1:0] mem_rdata;

  logic          cfg_acc, acc;
  logic [UW-1:0] cfg_u;
  logic [OW-1:0] ord_in, split_o;
  logic [PW-1:0] split_b, merge_b, pidx_pg;
  logic [SW-1:0] fit_end, free_sum;
  logic [UW-1:0] sub_a, sub_f;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_u     = (cfg_usable_pages == 11'd0) ? UW'(1) :
                     ((UW'(cfg_usable_pages) > MAX_U) ? MAX_U : UW'(cfg_usable_pages));

  assign in_ready  = (state_r == S_IDLE) && !clr_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd      = page_ent_t'(mem_rdata);
  assign ord_in  = order_of(UW'(in_data.page_count));
  assign split_o = co_r - 1'b1;
  assign split_b = blk_r ^ (PW'(1) << split_o);
  assign merge_b = blk_r ^ (PW'(1) << co_r);
  assign pidx_pg = PW'(pidx_r);
  assign fit_end = SW'(cur_r) + SW'(cnt_r) - 1'b1;
  assign sub_a   = usable_in(blk_r, ord_r, usable_r);
  assign sub_f   = usable_in(pidx_pg, rd.page_order, usable_r);
  assign free_sum = SW'(free_r) + SW'(sub_f);

  always_comb begin
    case (state_r)
      S_UL:    lidx = uo_r;
      S_SPLIT: lidx = split_o;
      S_MFO:   lidx = mfo_r;
      S_PUSH:  lidx = co_r;
      default: lidx = a_r;
    endcase
  end

  assign lf    = first_r[lidx];
  assign ll    = last_r[lidx];
  assign lfull = full_r[lidx];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    free_nxt      = free_r;
    mfo_nxt       = mfo_r;
    func_nxt      = func_r;
    cnt_nxt       = cnt_r;
    pidx_nxt      = pidx_r;
    tag_nxt       = tag_r;
    ord_nxt       = ord_r;
    a_nxt         = a_r;
    uo_nxt        = uo_r;
    co_nxt        = co_r;
    cur_nxt       = cur_r;
    blk_nxt       = blk_r;
    tgt_nxt       = tgt_r;
    lk_addr_nxt   = lk_addr_r;
    lk_val_nxt    = lk_val_r;
    res_st_nxt    = res_st_r;
    res_page_nxt  = res_page_r;
    res_pages_nxt = res_pages_r;
    res_tag_nxt   = res_tag_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    l_we_first    = 1'b0;
    l_we_last     = 1'b0;
    l_we_full     = 1'b0;
    l_full_val    = 1'b0;
    l_first_val   = '0;
    l_last_val    = '0;
    fsm_we        = 1'b0;
    fsm_waddr     = blk_r;
    fsm_wbe       = '0;
    fsm_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cur_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          func_nxt      = in_data.func;
          cnt_nxt       = in_data.page_count;
          pidx_nxt      = in_data.page_index;
          tag_nxt       = in_data.block_tag;
          res_st_nxt    = ST_BADIDX;
          res_page_nxt  = '0;
          res_pages_nxt = '0;
          res_tag_nxt   = '0;
          state_nxt     = S_RESP;
          case (in_data.func)
            FUNC_ALLOC: begin
              if (in_data.page_count == 11'd0) begin
                res_st_nxt = ST_ZERO;
              end else if (UW'(in_data.page_count) > usable_r) begin
                res_st_nxt = ST_BIG;
              end else if (mfo_r >= ord_in && free_r >= UW'(in_data.page_count)) begin
                ord_nxt   = ord_in;
                a_nxt     = ord_in;
                state_nxt = S_SCAN;
              end else begin
                res_st_nxt = ST_OOM;
              end
            end
            FUNC_FREE, FUNC_QUERY: begin
              if (UW'(in_data.page_index) < usable_r) begin
                mem_re    = 1'b1;
                mem_raddr = PW'(in_data.page_index);
                state_nxt = S_HREAD;
              end
            end
            default: begin
              res_st_nxt = ST_BADIDX;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (lfull) begin
          cur_nxt   = ll;
          state_nxt = S_CHECK;
        end else if (a_r == top_r) begin
          res_st_nxt = ST_OOM;
          state_nxt  = S_RESP;
        end else begin
          a_nxt = a_r + 1'b1;
        end
      end
      S_CHECK: begin
        mem_re    = 1'b1;
        mem_raddr = cur_r;
        if (fit_end < SW'(usable_r)) begin
          blk_nxt   = cur_r;
          state_nxt = S_AGET;
        end else if (cur_r == lf) begin
          if (a_r == top_r) begin
            res_st_nxt = ST_OOM;
            state_nxt  = S_RESP;
          end else begin
            a_nxt     = a_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cur_nxt   = rd.link_prev;
        state_nxt = S_CHECK;
      end
      S_AGET: begin
        tgt_nxt   = blk_r;
        uo_nxt    = rd.page_order;
        co_nxt    = rd.page_order;
        ret_nxt   = S_SPLIT;
        state_nxt = S_UL;
      end
      S_UL: begin
        fsm_we            = 1'b1;
        fsm_waddr         = tgt_r;
        fsm_wbe.on_list   = 1'b1;
        fsm_wdata.on_list = 1'b0;
        state_nxt         = ret_r;
        if (UW'(tgt_r) < usable_r && lfull) begin
          if (lf == tgt_r && ll == tgt_r) begin
            l_we_full  = 1'b1;
            l_full_val = 1'b0;
          end else if (lf == tgt_r) begin
            l_we_first  = 1'b1;
            l_first_val = rd.link_next;
          end else if (ll == tgt_r) begin
            l_we_last  = 1'b1;
            l_last_val = rd.link_prev;
          end else begin
            state_nxt = S_UL2;
          end
        end
      end
      S_UL2: begin
        fsm_we              = 1'b1;
        fsm_waddr           = rd.link_prev;
        fsm_wbe.link_next   = '1;
        fsm_wdata.link_next = rd.link_next;
        state_nxt           = S_UL3;
      end
      S_UL3: begin
        fsm_we              = 1'b1;
        fsm_waddr           = rd.link_next;
        fsm_wbe.link_prev   = '1;
        fsm_wdata.link_prev = rd.link_prev;
        state_nxt           = ret_r;
      end
      S_SPLIT: begin
        if (co_r > ord_r) begin
          fsm_we               = 1'b1;
          fsm_waddr            = split_b;
          fsm_wbe.page_order   = '1;
          fsm_wbe.on_list      = 1'b1;
          fsm_wdata.page_order = split_o;
          fsm_wdata.on_list    = 1'b1;
          fsm_wdata.link_prev  = ll;
          co_nxt               = split_o;
          if (UW'(split_b) < usable_r) begin
            l_we_last  = 1'b1;
            l_last_val = split_b;
            if (lfull) begin
              fsm_wbe.link_prev = '1;
              lk_addr_nxt       = ll;
              lk_val_nxt        = split_b;
              ret_nxt           = S_SPLIT;
              state_nxt         = S_LINK;
            end else begin
              l_we_first  = 1'b1;
              l_first_val = split_b;
              l_we_full   = 1'b1;
              l_full_val  = 1'b1;
            end
          end
        end else begin
          state_nxt = S_AFIN;
        end
      end
      S_LINK: begin
        fsm_we              = 1'b1;
        fsm_waddr           = lk_addr_r;
        fsm_wbe.link_next   = '1;
        fsm_wdata.link_next = lk_val_r;
        state_nxt           = ret_r;
      end
      S_AFIN: begin
        fsm_we               = 1'b1;
        fsm_waddr            = blk_r;
        fsm_wbe.page_order   = '1;
        fsm_wbe.on_list      = 1'b1;
        fsm_wbe.page_tag     = '1;
        fsm_wbe.is_head      = 1'b1;
        fsm_wdata.page_order = ord_r;
        fsm_wdata.on_list    = 1'b0;
        fsm_wdata.page_tag   = tag_r;
        fsm_wdata.is_head    = 1'b1;
        free_nxt             = (free_r > sub_a) ? free_r - sub_a : '0;
        res_st_nxt           = ST_OK;
        res_page_nxt         = blk_r;
        res_pages_nxt        = pages_of(ord_r);
        res_tag_nxt          = tag_r;
        state_nxt            = S_MFO;
      end
      S_MFO: begin
        if (mfo_r != '0 && !lfull) begin
          mfo_nxt = mfo_r - 1'b1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_HREAD: begin
        state_nxt = S_RESP;
        if (func_r == FUNC_QUERY) begin
          if (rd.is_head || rd.on_list) begin
            res_st_nxt    = ST_OK;
            res_page_nxt  = pidx_pg;
            res_pages_nxt = pages_of(rd.page_order);
            res_tag_nxt   = rd.is_head ? rd.page_tag : 4'd0;
          end
        end else if (rd.is_head) begin
          res_st_nxt         = ST_OK;
          res_page_nxt       = pidx_pg;
          res_pages_nxt      = pages_of(rd.page_order);
          free_nxt           = (free_sum > SW'(usable_r)) ? usable_r : UW'(free_sum);
          fsm_we             = 1'b1;
          fsm_waddr          = pidx_pg;
          fsm_wbe.page_tag   = '1;
          fsm_wbe.is_head    = 1'b1;
          fsm_wdata.page_tag = 4'd0;
          fsm_wdata.is_head  = 1'b0;
          blk_nxt            = pidx_pg;
          co_nxt             = rd.page_order;
          state_nxt          = S_MERGE;
        end
      end
      S_MERGE: begin
        if (co_r >= top_r) begin
          state_nxt = S_PUSH;
        end else begin
          tgt_nxt   = merge_b;
          mem_re    = 1'b1;
          mem_raddr = merge_b;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (rd.page_order != co_r || !rd.on_list) begin
          state_nxt = S_PUSH;
        end else begin
          uo_nxt    = co_r;
          ret_nxt   = S_MSTEP;
          state_nxt = S_UL;
        end
      end
      S_MSTEP: begin
        if (tgt_r < blk_r) blk_nxt = tgt_r;
        co_nxt    = co_r + 1'b1;
        state_nxt = S_MERGE;
      end
      S_PUSH: begin
        fsm_we               = 1'b1;
        fsm_waddr            = blk_r;
        fsm_wbe.page_order   = '1;
        fsm_wbe.on_list      = 1'b1;
        fsm_wdata.page_order = co_r;
        fsm_wdata.on_list    = 1'b1;
        fsm_wdata.link_prev  = ll;
        state_nxt            = S_RESP;
        if (UW'(blk_r) < usable_r) begin
          if (co_r > mfo_r) mfo_nxt = co_r;
          l_we_last  = 1'b1;
          l_last_val = blk_r;
          if (lfull) begin
            fsm_wbe.link_prev = '1;
            lk_addr_nxt       = ll;
            lk_val_nxt        = blk_r;
            ret_nxt           = S_RESP;
            state_nxt         = S_LINK;
          end else begin
            l_we_first  = 1'b1;
            l_first_val = blk_r;
            l_we_full   = 1'b1;
            l_full_val  = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status          = res_st_r;
          out_nxt.result_page     = 10'(res_page_r);
          out_nxt.block_pages     = res_pages_r;
          out_nxt.result_tag      = res_tag_r;
          out_nxt.free_page_total = 11'(free_r);
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (clr_r) begin
      mem_we               = 1'b1;
      mem_waddr            = clr_addr_r;
      mem_wbe              = '1;
      mem_wdata            = '0;
      mem_wdata.page_order = (clr_addr_r == '0) ? top_r : '0;
      mem_wdata.on_list    = (clr_addr_r == '0);
    end else begin
      mem_we    = fsm_we;
      mem_waddr = fsm_waddr;
      mem_wbe   = fsm_wbe;
      mem_wdata = fsm_wdata;
    end
  end

  bpa_page_mem #(
    .AW(PW),
    .DW(EW)
  ) u_page_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wbe   (mem_wbe),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      usable_r    <= MAX_U;
      top_r       <= TOP0;
      free_r      <= MAX_U;
      mfo_r       <= TOP0;
      for (int i = 0; i < NO; i++) begin
        full_r[i]  <= (OW'(i) == TOP0);
        first_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else if (cfg_acc) begin
      state_r     <= S_IDLE;
      out_valid_r <= out_valid_nxt;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      usable_r    <= cfg_u;
      top_r       <= order_of(cfg_u);
      free_r      <= cfg_u;
      mfo_r       <= order_of(cfg_u);
      for (int i = 0; i < NO; i++) begin
        full_r[i]  <= (OW'(i) == order_of(cfg_u));
        first_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      free_r      <= free_nxt;
      mfo_r       <= mfo_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) clr_r <= 1'b0;
      end
      if (l_we_first) first_r[lidx] <= l_first_val;
      if (l_we_last)  last_r[lidx]  <= l_last_val;
      if (l_we_full)  full_r[lidx]  <= l_full_val;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    cnt_r       <= cnt_nxt;
    pidx_r      <= pidx_nxt;
    tag_r       <= tag_nxt;
    ord_r       <= ord_nxt;
    a_r         <= a_nxt;
    uo_r        <= uo_nxt;
    co_r        <= co_nxt;
    cur_r       <= cur_nxt;
    blk_r       <= blk_nxt;
    tgt_r       <= tgt_nxt;
    lk_addr_r   <= lk_addr_nxt;
    lk_val_r    <= lk_val_nxt;
    res_st_r    <= res_st_nxt;
    res_page_r  <= res_page_nxt;
    res_pages_r <= res_pages_nxt;
    res_tag_r   <= res_tag_nxt;
    out_r       <= out_nxt;
  end

endmodule

FILE: design/bpa_page_mem.sv
// ----------------------------------------------------------------------------
// Buddy page allocator page memory
// Per-page state RAM: one bit-masked write port, one registered read port.
// ----------------------------------------------------------------------------
module bpa_page_mem #(
  parameter int AW = 10,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wbe,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < DW; i++) begin
        if (wbe[i]) begin
          mem_r[waddr][i] <= wdata[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bpa_checker.sv
// ----------------------------------------------------------------------------
// Buddy page allocator checker
// Port-level properties of the allocator response stream.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_macros.svh"

module bpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bpa_pkg::bpa_rsp_t out_data
);

  import bpa_pkg::*;

  `BPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "response changed while stalled")
  `BPA_ASSERT_NOW(a_status_range, out_valid, out_data.status <= ST_ZERO, "status code out of range")
  `BPA_ASSERT_NOW(a_err_zero, out_valid && out_data.status != ST_OK, out_data.result_page == 10'd0 && out_data.block_pages == 11'd0 && out_data.result_tag == 4'd0, "error response carries data")
  `BPA_ASSERT_NOW(a_ok_pow2, out_valid && out_data.status == ST_OK, $onehot(out_data.block_pages), "block size not a power of two")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_data         (out_data)
);
